>>> sv/ping_pong_audio_frame_player_defines.svh
// Assertion macros for the ping-pong audio frame player.
// Stand-alone header; needs no package and no other include.
`ifndef PING_PONG_AUDIO_FRAME_PLAYER_DEFINES_SVH
`define PING_PONG_AUDIO_FRAME_PLAYER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PPAFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPAFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ppafp_pkg.sv
// Shared constants, codes and types of the ping-pong audio frame player.
// No dependencies; compiled first.
package ppafp_pkg;

    localparam int FRAMES     = 4096;
    localparam int HALF       = FRAMES / 2;
    localparam int POS_W      = $clog2(FRAMES);
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 15;
    localparam int ACT_W      = 3;
    localparam int IDX_W      = 12;
    localparam int Q_SHIFT    = 15;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W      = $clog2(OUTQ_DEPTH + 1);

    localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(16383);

    typedef enum logic [ACT_W-1:0] {
        ACT_REQUEST = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_REFILL  = 3'd2,
        ACT_START   = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_PAUSE   = 3'd5
    } t_action;

    typedef enum logic {
        REG_VOLUME = 1'b0,
        REG_ENABLE = 1'b1
    } t_cfg_reg;

    // Store word: left in the low half, right in the high half.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } t_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       ok;
    } t_result;

endpackage

>>> sv/ppafp_if.sv
// Valid/ready channel interfaces for the request and result beats.
// Depends on ppafp_pkg.
interface ppafp_in_if import ppafp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic [IDX_W-1:0]           frame_index;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       half_select;
    logic                       pause_value;

    modport source (output valid, action, frame_index, left_in, right_in,
                    half_select, pause_value, input ready);
    modport sink   (input valid, action, frame_index, left_in, right_in,
                    half_select, pause_value, output ready);
endinterface

interface ppafp_out_if import ppafp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       ok;

    modport source (output valid, left_out, right_out, ok, input ready);
    modport sink   (input valid, left_out, right_out, ok, output ready);
endinterface

>>> sv/ppafp_store.sv
// Frame store: single-port-write, registered-read synchronous RAM.
// Depends on ppafp_pkg.
module ppafp_store import ppafp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [POS_W-1:0] i_waddr,
    input  t_frame           i_wdata,
    input  logic             i_re,
    input  logic [POS_W-1:0] i_raddr,
    output t_frame           o_rdata
);

    t_frame mem [FRAMES];
    t_frame r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ppafp_outq.sv
// Small result queue that decouples the pipeline from the result sink.
// Depends on ppafp_pkg; the caller keeps it from overflowing.
module ppafp_outq import ppafp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr;
    logic [OUTQ_PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   do_pop;

    assign o_valid = (r_cnt != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + OUTQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + OUTQ_PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

endmodule

>>> sv/ping_pong_audio_frame_player.sv
// Ping-pong audio frame player: the top level.
// Depends on ppafp_pkg, ppafp_if, ppafp_store, ppafp_outq and the defines header.
//
// Usage:
//   i_in carries one action per beat: request frame, write frame, half
//   refilled, start, stop, pause/resume. Only a request produces a result
//   beat on o_out: the scaled stereo frame with ok=1, or zeros with ok=0
//   when the block is disabled, stopped, paused or the current half is stale.
//   Control actions take effect at the beat itself, so the next beat sees them.
//   A result passes the store read, the multiply register and the queue
//   before it is offered. Throughput: one beat per cycle while i_in.ready
//   is high; the frame store takes one write and one read per cycle and
//   the two 16x16 multipliers are pipelined.
//   i_in.ready stays high while fewer than four requests are outstanding
//   (in flight or waiting in the result queue). When the sink stalls, the
//   queue fills and ready drops after up to four requests; writes and
//   control beats then wait with them.
//   Reset clears position, flags and queue; volume returns to 16383 and
//   enable to 1. The store keeps its contents and needs no clearing pass.
//   Write the registers on i_cfg_* only while no request is outstanding.
`include "ping_pong_audio_frame_player_defines.svh"

module ping_pong_audio_frame_player import ppafp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [VOL_W-1:0] i_cfg_data,
    ppafp_in_if.sink         i_in,
    ppafp_out_if.source      o_out
);

    // Configuration registers.
    logic [VOL_W-1:0] r_volume;
    logic             r_enable;

    // Playback state.
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [1:0]       r_stale,   n_stale;
    logic             r_playing, n_playing;
    logic             r_paused,  n_paused;

    // Outstanding requests (pipeline plus queue).
    logic [CNT_W-1:0] r_pend;

    // Pipeline stages.
    logic             r_s1_vld;
    logic             r_s1_ok;
    logic             r_s2_vld;
    t_result          r_s2_res;

    logic             accept;
    logic             pop;
    t_action          act;
    logic             is_req;
    logic             cur_half;
    logic             play_ok;
    logic             store_we;
    logic [31:0]      idx_ext;
    t_frame           wr_frame;
    t_frame           rd_frame;
    logic signed [2*SAMPLE_W-1:0] prod_l;
    logic signed [2*SAMPLE_W-1:0] prod_r;
    logic             q_valid;
    t_result          q_data;

    assign accept   = i_in.valid && i_in.ready;
    assign pop      = o_out.valid && o_out.ready;
    assign act      = t_action'(i_in.action);
    assign is_req   = accept && (act == ACT_REQUEST);
    assign cur_half = r_pos[POS_W-1];
    assign play_ok  = r_enable && r_playing && !r_paused && !r_stale[cur_half];

    // Hold off new beats once the result queue could overflow.
    assign i_in.ready = (r_pend < CNT_W'(OUTQ_DEPTH));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOL_RESET;
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_VOLUME: r_volume <= i_cfg_data;
                REG_ENABLE: r_enable <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Playback state update: advance on a played frame, act on control beats while enabled.
    always_comb begin
        n_pos     = r_pos;
        n_stale   = r_stale;
        n_playing = r_playing;
        n_paused  = r_paused;
        if (accept) begin
            if (act == ACT_REQUEST) begin
                if (play_ok) begin
                    if (r_pos == POS_W'(FRAMES - 1)) begin
                        n_pos      = '0;
                        n_stale[1] = 1'b1;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                        if (r_pos == POS_W'(HALF - 1)) begin
                            n_stale[0] = 1'b1;
                        end
                    end
                end
            end else if (r_enable) begin
                case (act)
                    ACT_REFILL: n_stale[i_in.half_select] = 1'b0;
                    ACT_START: begin
                        n_pos     = '0;
                        n_stale   = 2'b00;
                        n_playing = 1'b1;
                        n_paused  = 1'b0;
                    end
                    ACT_STOP: begin
                        n_playing = 1'b0;
                        n_stale   = 2'b11;
                    end
                    ACT_PAUSE: n_paused = i_in.pause_value;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_stale   <= 2'b00;
            r_playing <= 1'b0;
            r_paused  <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_stale   <= n_stale;
            r_playing <= n_playing;
            r_paused  <= n_paused;
        end
    end

    // Frame store: write on a write beat inside the store, read the play position.
    assign idx_ext        = 32'(i_in.frame_index);
    assign store_we       = accept && (act == ACT_WRITE) && r_enable
                            && (idx_ext < 32'(FRAMES));
    assign wr_frame.left  = i_in.left_in;
    assign wr_frame.right = i_in.right_in;

    ppafp_store u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (idx_ext[POS_W-1:0]),
        .i_wdata (wr_frame),
        .i_re    (is_req && play_ok),
        .i_raddr (r_pos),
        .o_rdata (rd_frame)
    );

    // Stage 1: store data arrives; carry the request's verdict alongside.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= is_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok <= play_ok;
    end

    // Stage 2: Q15 scale, floor by arithmetic shift; zero the samples of an idle answer.
    assign prod_l = rd_frame.left  * $signed({1'b0, r_volume});
    assign prod_r = rd_frame.right * $signed({1'b0, r_volume});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_res.ok    <= r_s1_ok;
        r_s2_res.left  <= r_s1_ok ? prod_l[Q_SHIFT+SAMPLE_W-1:Q_SHIFT] : '0;
        r_s2_res.right <= r_s1_ok ? prod_r[Q_SHIFT+SAMPLE_W-1:Q_SHIFT] : '0;
    end

    // Result queue towards the sink.
    ppafp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_vld),
        .i_data  (r_s2_res),
        .i_pop   (o_out.ready),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign o_out.valid     = q_valid;
    assign o_out.left_out  = q_data.left;
    assign o_out.right_out = q_data.right;
    assign o_out.ok        = q_data.ok;

    // Count requests from their beat until their result beat leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + CNT_W'(is_req) - CNT_W'(pop);
        end
    end

    `PPAFP_ASSERT_NOW(a_pend_bound, i_clk, i_rst_n, 1'b1,
                      r_pend <= CNT_W'(OUTQ_DEPTH), "outstanding requests exceed queue depth")
    `PPAFP_ASSERT_NOW(a_result_owed, i_clk, i_rst_n, o_out.valid,
                      r_pend != '0, "result offered with no request outstanding")
    `PPAFP_ASSERT_NEXT(a_play_advances, i_clk, i_rst_n, is_req && play_ok,
                       r_pos != $past(r_pos), "played frame did not move the position")

endmodule

>>> tb/ppafp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ping-pong audio frame player: mirrors its state and predicts each result.
// Depends on ppafp_pkg and the channel interfaces in ppafp_if.
module ppafp_checker import ppafp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [VOL_W-1:0] i_cfg_data,
    ppafp_in_if              i_req,
    ppafp_out_if             i_res,
    output int               o_errors,
    output int               o_pending
);

    t_frame           frames [FRAMES];
    logic [POS_W-1:0] play_pos;
    logic             half_stale [2];
    logic             playing;
    logic             paused;
    logic             enabled;
    logic [VOL_W-1:0] gain;
    t_result          due_frames [$];
    int               mismatches = 0;

    assign o_errors = mismatches;

    // floor(sample * gain / 2^15); the arithmetic shift rounds towards minus infinity
    function automatic logic signed [SAMPLE_W-1:0] apply_gain(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [VOL_W-1:0]           g
    );
        logic signed [31:0] prod;
        prod = smp * $signed({1'b0, g});
        prod = prod >>> Q_SHIFT;
        return prod[SAMPLE_W-1:0];
    endfunction

    task automatic take_action();
        t_result r;
        logic    h;
        if (i_req.action == ACT_REQUEST) begin
            r = '0;
            h = play_pos[POS_W-1];
            if (enabled && playing && !paused && !half_stale[h]) begin
                r.left  = apply_gain(frames[play_pos].left, gain);
                r.right = apply_gain(frames[play_pos].right, gain);
                r.ok    = 1'b1;
                // last frame of a half: mark it stale; the position wraps by itself
                if (&play_pos[POS_W-2:0])
                    half_stale[h] = 1'b1;
                play_pos = play_pos + 1'b1;
            end
            due_frames.push_back(r);
        end else if (enabled) begin
            case (i_req.action)
                ACT_WRITE:  frames[i_req.frame_index] = {i_req.right_in, i_req.left_in};
                ACT_REFILL: half_stale[i_req.half_select] = 1'b0;
                ACT_START: begin
                    play_pos      = '0;
                    half_stale[0] = 1'b0;
                    half_stale[1] = 1'b0;
                    playing       = 1'b1;
                    paused        = 1'b0;
                end
                ACT_STOP: begin
                    playing       = 1'b0;
                    half_stale[0] = 1'b1;
                    half_stale[1] = 1'b1;
                end
                ACT_PAUSE:  paused = i_req.pause_value;
                default: ;
            endcase
        end
    endtask

    task automatic match_frame();
        t_result want;
        if (due_frames.size() == 0) begin
            $error("result beat with no request waiting: left_out %0d right_out %0d ok %0b",
                   i_res.left_out, i_res.right_out, i_res.ok);
            mismatches++;
        end else begin
            want = due_frames.pop_front();
            if (i_res.left_out !== want.left) begin
                $error("left_out: expected %0d, got %0d", want.left, i_res.left_out);
                mismatches++;
            end
            if (i_res.right_out !== want.right) begin
                $error("right_out: expected %0d, got %0d", want.right, i_res.right_out);
                mismatches++;
            end
            if (i_res.ok !== want.ok) begin
                $error("ok: expected %0b, got %0b", want.ok, i_res.ok);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            play_pos      = '0;
            half_stale[0] = 1'b0;
            half_stale[1] = 1'b0;
            playing       = 1'b0;
            paused        = 1'b0;
            enabled       = 1'b1;
            gain          = VOL_RESET;
            due_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VOLUME: gain    = i_cfg_data;
                    REG_ENABLE: enabled = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready)
                match_frame();
            if (i_req.valid && i_req.ready)
                take_action();
        end
        o_pending <= due_frames.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the ping-pong audio frame player: clock, reset, stimulus and verdict.
// Depends on ppafp_pkg, ppafp_if, ppafp_checker and the player RTL.
module tb_top;
    import ppafp_pkg::*;

    // action codes the block must ignore
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int SETTLE        = 4;     // settle time after the drain, beyond the pipeline latency
    localparam int QUIET_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_BEATS   = 200;
    localparam int FILL_FRAMES   = 256;   // frames written before the random phases

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_reg         cfg_reg;
    logic [VOL_W-1:0] cfg_data;
    int               errors;
    int               pending;

    bit               burst_mode;   // when set, neither side inserts idle cycles
    int               beats_sent;
    bit               cur_enable;   // enable as last written to the player
    int               play_bound;   // requests since the last start that took effect

    ppafp_in_if  in_ch ();
    ppafp_out_if out_ch ();

    ping_pong_audio_frame_player dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_reg),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    ppafp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_reg),
        .i_cfg_data (cfg_data),
        .i_req      (in_ch),
        .i_res      (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Favour the full-scale and near-zero samples; otherwise any 16-bit pattern.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one beat after a random gap and hold it until the player takes it.
    task automatic put_beat(input logic [ACT_W-1:0]    act,
                            input logic [IDX_W-1:0]    idx,
                            input logic [SAMPLE_W-1:0] lft,
                            input logic [SAMPLE_W-1:0] rgt,
                            input logic                hsel,
                            input logic                pval);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.frame_index <= idx;
        in_ch.left_in     <= lft;
        in_ch.right_in    <= rgt;
        in_ch.half_select <= hsel;
        in_ch.pause_value <= pval;
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
        // the play position never runs ahead of this count
        if (act == ACT_REQUEST)
            play_bound++;
        else if (act == ACT_START && cur_enable)
            play_bound = 0;
    endtask

    // Random filler in the fields that this action does not use.
    task automatic put_action(input logic [ACT_W-1:0] act, input logic hsel, input logic pval);
        put_beat(act, IDX_W'($urandom), pick_sample(), pick_sample(), hsel, pval);
    endtask

    // Restart first if the position could have left the filled frames.
    task automatic put_request();
        if (play_bound >= FILL_FRAMES)
            put_action(ACT_START, 1'($urandom), 1'($urandom));
        put_action(ACT_REQUEST, 1'($urandom), 1'($urandom));
    endtask

    task automatic put_random_write();
        put_beat(ACT_WRITE, IDX_W'($urandom), pick_sample(), pick_sample(),
                 1'($urandom), 1'($urandom));
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [VOL_W-1:0] vol, input logic en);
        cfg_we   <= 1'b1;
        cfg_reg  <= REG_VOLUME;
        cfg_data <= vol;
        @(posedge i_clk);
        cfg_reg  <= REG_ENABLE;
        cfg_data <= VOL_W'(en);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_enable = en;
    endtask

    // One short sequence of what software would do, with some noise mixed in.
    task automatic play_episode();
        int               pick;
        logic [ACT_W-1:0] act;
        burst_mode = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            repeat ($urandom_range(1, 40)) put_request();
        end else if (pick < 70) begin
            // refill: a few frames, then hand the half back
            repeat ($urandom_range(1, 6)) put_random_write();
            put_action(ACT_REFILL, 1'($urandom), 1'($urandom));
        end else if (pick < 78) begin
            put_action(ACT_START, 1'($urandom), 1'($urandom));
        end else if (pick < 86) begin
            // pause, poll a little, and usually resume; sometimes leave it paused
            put_action(ACT_PAUSE, 1'($urandom), 1'b1);
            repeat ($urandom_range(0, 4)) put_request();
            if ($urandom_range(0, 3) != 0)
                put_action(ACT_PAUSE, 1'($urandom), 1'b0);
        end else if (pick < 91) begin
            put_action(ACT_STOP, 1'($urandom), 1'($urandom));
        end else begin
            act = ACT_W'($urandom_range(0, 7));
            if (act == ACT_REQUEST)
                put_request();
            else
                put_beat(act, IDX_W'($urandom), SAMPLE_W'($urandom),
                         SAMPLE_W'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // Result side: outside burst mode, insert a random stall before each beat.
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no beat on either channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [VOL_W-1:0] vol;
        int               target;

        // Hold every input at a known value while reset is low.
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_reg           <= REG_VOLUME;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_REQUEST;
        in_ch.frame_index <= '0;
        in_ch.left_in     <= '0;
        in_ch.right_in    <= '0;
        in_ch.half_select <= 1'b0;
        in_ch.pause_value <= 1'b0;
        burst_mode        = 1'b0;
        beats_sent        = 0;
        cur_enable        = 1'b1;
        play_bound        = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every action at its edges, with the reset volume.
        put_request();                                  // stopped after reset: zeros
        put_action(ACT_SPARE_LO, 1'b1, 1'b1);           // unused codes: no result
        put_action(ACT_SPARE_HI, 1'b0, 1'b0);
        put_action(ACT_PAUSE, 1'b0, 1'b1);
        put_action(ACT_START, 1'b1, 1'b1);              // start also clears the pause
        put_beat(ACT_WRITE, IDX_W'(0), 16'h7FFF, 16'h8000, 1'b0, 1'b0);
        put_beat(ACT_WRITE, IDX_W'(1), 16'h8000, 16'h7FFF, 1'b1, 1'b1);
        put_beat(ACT_WRITE, IDX_W'(2), 16'hFFFF, 16'h0001, 1'b0, 1'b1);
        put_beat(ACT_WRITE, IDX_W'(3), 16'h0000, 16'hFFFF, 1'b1, 1'b0);
        put_beat(ACT_WRITE, '1, 16'h5A5A, 16'hA5A5, 1'b0, 1'b0);
        repeat (4) put_request();                       // play positions 0 to 3
        put_action(ACT_PAUSE, 1'b0, 1'b1);
        put_request();                                  // paused: zeros, no advance
        put_action(ACT_PAUSE, 1'b1, 1'b0);
        put_action(ACT_REFILL, 1'b1, 1'b0);             // refill of a fresh half
        put_action(ACT_STOP, 1'b0, 1'b1);
        put_request();                                  // stopped: zeros
        put_action(ACT_REFILL, 1'b0, 1'b1);
        put_action(ACT_START, 1'b0, 1'b0);
        put_request();                                  // back to position 0

        // Hold off until every result is back: full and zero volume on the same frames.
        wait_drained();
        set_config('1, 1'b1);
        put_action(ACT_START, 1'b1, 1'b0);
        repeat (4) put_request();
        wait_drained();
        set_config('0, 1'b1);
        put_action(ACT_START, 1'b0, 1'b1);
        repeat (4) put_request();
        wait_drained();

        // Fill the start of the store; requests restart before they could leave it.
        for (int a = 0; a < FILL_FRAMES; a++) begin
            if (a % 64 == 0)
                burst_mode = ($urandom_range(0, 1) == 0);
            put_beat(ACT_WRITE, IDX_W'(a), pick_sample(), pick_sample(),
                     1'($urandom), 1'($urandom));
        end

        // Random phases: full, zero, minimum and random volume; one phase disabled.
        for (int p = 0; p < RAND_PHASES; p++) begin
            vol = VOL_W'($urandom);
            if (p == 0)
                vol = '1;
            else if (p == 1)
                vol = '0;
            else if (p == 2)
                vol = VOL_W'(1);
            wait_drained();
            set_config(vol, p != 4);
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
                play_episode();
        end

        wait_drained();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
